@@ design/rbd_pkg.sv @@
// ----------------------------------------------------------------------------
// rbd_pkg: shared types and constants for the ring buffer deque
// Operation and status codes, field widths and the per-item control bundle
// passed from the step logic to the top level.
// ----------------------------------------------------------------------------
package rbd_pkg;

  // Fixed field widths of the item and register formats
  localparam int OP_W  = 3;
  localparam int VAL_W = 32;
  localparam int POS_W = 4;
  localparam int CNT_W = 5;
  localparam int ST_W  = 2;

  // Operation codes carried in each input item
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_READ       = 3'd4,
    OP_CLEAR      = 3'd5
  } op_t;

  // Result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Register index of the ring size register
  localparam int REG_CAPACITY = 0;

  // Per-item outcome from the step logic
  typedef struct packed {
    logic [CNT_W-1:0] head_nxt;  // new front index
    logic [CNT_W-1:0] fill_nxt;  // new element count
    status_t          status;    // result status
    logic             wr_en;     // store the pushed element
    logic [CNT_W-1:0] wr_idx;    // ring slot for the push
    logic             rd_ok;     // read hits a held element
    logic [CNT_W-1:0] rd_idx;    // ring slot for the read
  } step_t;

endpackage

@@ design/rbd_step_logic.sv @@
// ----------------------------------------------------------------------------
// rbd_step_logic: next-state logic for one deque operation
// Works out the new head and count, the status and the ring slots to write
// or read, from the current head, count and ring size.
// ----------------------------------------------------------------------------
module rbd_step_logic
  import rbd_pkg::*;
(
  input  op_t              op,
  input  logic [POS_W-1:0] position,
  input  logic [CNT_W-1:0] head,
  input  logic [CNT_W-1:0] fill,
  input  logic [CNT_W-1:0] size,
  output step_t            step
);

  // Wrap a sum that stays below twice the ring size
  function automatic logic [CNT_W-1:0] wrap(input logic [CNT_W:0] a,
                                            input logic [CNT_W-1:0] sz);
    logic [CNT_W:0] sz_ext;
    logic [CNT_W:0] diff;
    sz_ext = {1'b0, sz};
    diff   = a - sz_ext;
    return (a >= sz_ext) ? diff[CNT_W-1:0] : a[CNT_W-1:0];
  endfunction

  logic [CNT_W-1:0] front_dec_idx;
  logic [CNT_W-1:0] back_idx;
  logic [CNT_W-1:0] front_inc_idx;
  logic [CNT_W-1:0] pos_idx;
  logic             is_full;
  logic             is_empty;
  logic             pos_ok;

  // Ring slots for each kind of access
  assign front_dec_idx = wrap({1'b0, head} + {1'b0, size} - {{CNT_W{1'b0}}, 1'b1}, size);
  assign back_idx      = wrap({1'b0, head} + {1'b0, fill}, size);
  assign front_inc_idx = wrap({1'b0, head} + {{CNT_W{1'b0}}, 1'b1}, size);
  assign pos_idx       = wrap({1'b0, head} + (CNT_W+1)'(position), size);

  assign is_full  = (fill >= size);
  assign is_empty = (fill == '0);
  assign pos_ok   = (CNT_W'(position) < fill);

  // Decode the operation
  always_comb begin
    step.head_nxt = head;
    step.fill_nxt = fill;
    step.status   = ST_OK;
    step.wr_en    = 1'b0;
    step.wr_idx   = back_idx;
    step.rd_ok    = 1'b0;
    step.rd_idx   = pos_idx;
    case (op)
      OP_PUSH_FRONT: begin
        if (is_full) begin
          step.status = ST_FULL;
        end else begin
          step.head_nxt = front_dec_idx;
          step.fill_nxt = fill + 1'b1;
          step.wr_en    = 1'b1;
          step.wr_idx   = front_dec_idx;
        end
      end
      OP_PUSH_BACK: begin
        if (is_full) begin
          step.status = ST_FULL;
        end else begin
          step.fill_nxt = fill + 1'b1;
          step.wr_en    = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (is_empty) begin
          step.status = ST_EMPTY;
        end else begin
          step.head_nxt = front_inc_idx;
          step.fill_nxt = fill - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (is_empty) begin
          step.status = ST_EMPTY;
        end else begin
          step.fill_nxt = fill - 1'b1;
        end
      end
      OP_READ: begin
        if (pos_ok) begin
          step.rd_ok = 1'b1;
        end else begin
          step.status = ST_RANGE;
        end
      end
      OP_CLEAR: begin
        step.head_nxt = '0;
        step.fill_nxt = '0;
      end
      default: begin
        // unused codes leave the deque untouched
      end
    endcase
  end

endmodule

@@ design/ring_buffer_deque.sv @@
// ----------------------------------------------------------------------------
// ring_buffer_deque: fixed-capacity double-ended queue on a circular store
// Push and pop at either end, read by position from the front, and clear.
// The ring size in use is set by the capacity register.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Contents
//  in_      slave      in_tvalid/in_tready    operation, value, position
//  out_     master     out_tvalid/out_tready  read_value, count, status
//  cfg_     APB slave  psel/penable/pready    capacity at byte address 0
//
// One item per cycle while no result waits on a low out_tready; the result register loads at the accepting edge.
// Head, count and store update at the accepting edge; the store read port
// registers its data at the same edge, so a read sees every earlier push.
// in_tready is low only while a result waits and out_tready is low.
// Reset (rst_n, synchronous) empties the deque and sets capacity to 16,
// limited to DEPTH; store contents are not cleared. A capacity write empties
// the deque too.
// ----------------------------------------------------------------------------
module ring_buffer_deque
  import rbd_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // operation[2:0], value[34:3], position[38:35]
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // read_value[31:0], count[36:32], status[38:37]
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // State
  logic [CNT_W-1:0]      head_r, head_nxt;
  logic [CNT_W-1:0]      fill_r, fill_nxt;
  logic [CNT_W-1:0]      cap_r;
  logic                  out_valid_r;
  logic [CNT_W-1:0]      out_count_r;
  status_t               out_status_r;
  logic                  out_rd_ok_r;
  logic [ELEM_WIDTH-1:0] mem [DEPTH];
  logic [ELEM_WIDTH-1:0] mem_q_r;

  logic             in_acc;
  logic             cfg_wr;
  op_t              in_op;
  logic [VAL_W-1:0] in_value;
  logic [POS_W-1:0] in_pos;
  logic [31:0]      cap_ext;
  logic [31:0]      size_ext;
  logic [CNT_W-1:0] size;
  step_t            step;
  logic [31:0]      wr_idx_ext;
  logic [31:0]      rd_idx_ext;
  logic [63:0]      wr_val_ext;
  logic [63:0]      rd_val_ext;

  // Unpack the input item
  assign in_op    = op_t'(in_tdata[2:0]);
  assign in_value = in_tdata[34:3];
  assign in_pos   = in_tdata[38:35];

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (32'(cfg_paddr[2]) == REG_CAPACITY);
  assign cfg_prdata = (32'(cfg_paddr[2]) == REG_CAPACITY) ? 32'(cap_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CNT_W'(16);
    end else if (cfg_wr) begin
      cap_r <= cfg_pwdata[CNT_W-1:0];
    end
  end

  // Ring size: zero acts as one, limit to the store depth
  assign cap_ext  = 32'(cap_r);
  assign size_ext = (cap_ext == 32'd0) ? 32'd1 :
                    (cap_ext > 32'(DEPTH)) ? 32'(DEPTH) : cap_ext;
  assign size     = size_ext[CNT_W-1:0];

  rbd_step_logic u_step (
    .op       (in_op),
    .position (in_pos),
    .head     (head_r),
    .fill     (fill_r),
    .size     (size),
    .step     (step)
  );

  // Advance head and count on an accepted item, empty on a capacity write
  always_comb begin
    head_nxt = head_r;
    fill_nxt = fill_r;
    if (cfg_wr) begin
      head_nxt = '0;
      fill_nxt = '0;
    end else if (in_acc) begin
      head_nxt = step.head_nxt;
      fill_nxt = step.fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
    end
  end

  // Element store: one write port, one registered read port
  assign wr_idx_ext = 32'(step.wr_idx);
  assign rd_idx_ext = 32'(step.rd_idx);
  assign wr_val_ext = 64'(in_value);

  always_ff @(posedge clk) begin
    if (in_acc && step.wr_en) begin
      mem[wr_idx_ext[AW-1:0]] <= wr_val_ext[ELEM_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem_q_r <= mem[rd_idx_ext[AW-1:0]];
    end
  end

  // Result register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_count_r  <= step.fill_nxt;
      out_status_r <= step.status;
      out_rd_ok_r  <= step.rd_ok;
    end
  end

  // Pack the result item, zero read data unless the read hit
  assign rd_val_ext = 64'(mem_q_r);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_status_r, out_count_r,
                       out_rd_ok_r ? rd_val_ext[VAL_W-1:0] : {VAL_W{1'b0}}};

  // Checks
  a_fill_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= size)
    else $error("element count exceeds ring size");

  a_head_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    head_r < size)
    else $error("head index outside ring");

  a_cfg_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> (fill_r == '0) && (head_r == '0))
    else $error("capacity write did not empty the deque");

  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ST_RANGE) |-> (out_tdata[31:0] == '0))
    else $error("out-of-range read returned data");

endmodule

@@ sim/tb_ring_buffer_deque.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ring_buffer_deque: self-checking bench for the ring buffer deque
// Drives push, pop, read and clear items under random gaps and back-pressure,
// predicts each result from a private copy of the ring, and reprograms the
// capacity between phases, including the zero and over-range settings.
// ----------------------------------------------------------------------------
module tb_ring_buffer_deque;
  import rbd_pkg::*;

  localparam int RING_MAX   = 16;
  localparam int CYCLE_CAP  = 400000;
  localparam int SEG_ITEMS  = 195;
  localparam int NUM_SEGS   = 9;
  // Codes the block treats as no-ops
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

  typedef struct {
    logic [VAL_W-1:0] read_value;
    logic [CNT_W-1:0] count;
    status_t          status;
  } deque_result_t;

  // Tracks the ring contents and holds the results still owed by the block
  class ring_deque_tracker;
    logic [VAL_W-1:0] slots [RING_MAX];
    int unsigned      head;
    int unsigned      fill;
    logic [CNT_W-1:0] capacity;
    deque_result_t    pending_results[$];
    int               mismatches;
    int               checked;
    int               status_seen[4];

    function new();
      head = 0;
      fill = 0;
      capacity = 5'd16;
      mismatches = 0;
      checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // Zero acts as one, anything past the store acts as the full store
    function int unsigned ring_size();
      if (capacity == 0) return 1;
      if (capacity > RING_MAX) return RING_MAX;
      return capacity;
    endfunction

    function void set_capacity(logic [CNT_W-1:0] cap);
      capacity = cap;
      head = 0;
      fill = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    // Apply one accepted item and queue the result it must produce
    function void note_op(logic [39:0] item);
      logic [OP_W-1:0]  op;
      logic [VAL_W-1:0] val;
      logic [POS_W-1:0] pos;
      int unsigned      size;
      deque_result_t    res;
      op  = item[2:0];
      val = item[34:3];
      pos = item[38:35];
      size = ring_size();
      res.read_value = '0;
      res.status = ST_OK;
      if (head >= size) head = 0;
      if (fill > size) fill = size;
      case (op)
        OP_PUSH_FRONT: begin
          if (fill < size) begin
            head = (head + size - 1) % size;
            slots[head] = val;
            fill++;
          end else begin
            res.status = ST_FULL;
          end
        end
        OP_PUSH_BACK: begin
          if (fill < size) begin
            slots[(head + fill) % size] = val;
            fill++;
          end else begin
            res.status = ST_FULL;
          end
        end
        OP_POP_FRONT: begin
          if (fill > 0) begin
            head = (head + 1) % size;
            fill--;
          end else begin
            res.status = ST_EMPTY;
          end
        end
        OP_POP_BACK: begin
          if (fill > 0) fill--;
          else res.status = ST_EMPTY;
        end
        OP_READ: begin
          if (pos < fill) res.read_value = slots[(head + pos) % size];
          else res.status = ST_RANGE;
        end
        OP_CLEAR: begin
          head = 0;
          fill = 0;
        end
        default: ;
      endcase
      res.count = fill[CNT_W-1:0];
      pending_results.push_back(res);
    endfunction

    // Compare one result with the oldest one owed
    task check_result(logic [39:0] item);
      deque_result_t exp;
      if (pending_results.size() == 0) begin
        report($sformatf("result %h arrived with none owed", item));
        return;
      end
      exp = pending_results.pop_front();
      checked++;
      status_seen[exp.status]++;
      if (item[31:0] !== exp.read_value)
        report($sformatf("read_value %h, want %h", item[31:0], exp.read_value));
      if (item[36:32] !== exp.count)
        report($sformatf("count %0d, want %0d", item[36:32], exp.count));
      if (item[38:37] !== exp.status)
        report($sformatf("status %0d, want %0d", item[38:37], exp.status));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;    // operation[2:0], value[34:3], position[38:35]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;        // read_value[31:0], count[36:32], status[38:37]
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  ring_deque_tracker deque = new();
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int cycles = 0;
  int items_sent = 0;
  int cap_writes = 0;

  ring_buffer_deque DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up if the run hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("[%0t] timeout after %0d cycles", $time, cycles);
      $display("tb_ring_buffer_deque: FAIL");
      $finish;
    end
  end

  // Random back-pressure on the result side
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Check results before noting new items: a result never comes from the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) deque.check_result(out_tdata);
      if (in_tvalid && in_tready) deque.note_op(in_tdata);
    end
  end

  // Offer one item, idling first at random, and hold it until taken
  task automatic send_item(logic [OP_W-1:0] op, logic [VAL_W-1:0] val,
                           logic [POS_W-1:0] pos);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, pos, val, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (deque.pending() != 0) @(posedge clk);
  endtask

  // Capacity writes only with nothing in flight
  task automatic write_capacity(logic [CNT_W-1:0] cap);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 3'(REG_CAPACITY * 4);
    cfg_pwdata  <= 32'(cap);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    deque.set_capacity(cap);
    cap_writes++;
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return $urandom;
  endfunction

  // One random item; lean selects filling (0), draining (1) or balance (2)
  task automatic random_item(int lean);
    int               r;
    int               push_pct;
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    r = $urandom_range(0, 99);
    pos = POS_W'($urandom_range(0, RING_MAX - 1));
    push_pct = (lean == 0) ? 75 : (lean == 1) ? 25 : 50;
    if (r < 1) begin
      op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
    end else if (r < 3) begin
      op = OP_CLEAR;
    end else if (r < 22) begin
      op = OP_READ;
      if (deque.fill > 0 && $urandom_range(0, 99) < 80)
        pos = POS_W'($urandom_range(0, deque.fill - 1));
    end else if ($urandom_range(0, 99) < push_pct) begin
      op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    end else begin
      op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
    end
    send_item(op, pick_value(), pos);
  endtask

  initial begin
    logic [CNT_W-1:0] seg_caps [NUM_SEGS];
    int               done;
    int               burst;
    int               lean;
    seg_caps = '{5'd31, 5'd3, 5'd0, 5'd16, 5'd1, 5'd7, 5'd16, 5'd2, 5'd0};
    seg_caps[NUM_SEGS-1] = CNT_W'($urandom_range(0, 31));

    // Hold reset, then release on an edge
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty-deque cases and no-op codes at the reset capacity
    send_item(OP_POP_FRONT, '0, '0);
    send_item(OP_POP_BACK, '0, '0);
    send_item(OP_READ, '0, 4'd0);
    send_item(OP_READ, '0, 4'd15);
    send_item(OP_SPARE_A, '1, 4'd15);
    send_item(OP_SPARE_B, '1, 4'd0);
    // Push at both ends, read each slot and one past the end
    send_item(OP_PUSH_FRONT, 32'hFFFF_FFFF, '0);
    send_item(OP_PUSH_BACK, 32'h0000_0000, '1);
    send_item(OP_PUSH_FRONT, 32'h1234_5678, '0);
    send_item(OP_READ, '0, 4'd0);
    send_item(OP_READ, '0, 4'd1);
    send_item(OP_READ, '0, 4'd2);
    send_item(OP_READ, '0, 4'd3);
    send_item(OP_POP_BACK, '0, '0);
    send_item(OP_POP_FRONT, '0, '0);
    send_item(OP_READ, '0, 4'd0);
    send_item(OP_CLEAR, '0, '0);
    send_item(OP_READ, '0, 4'd0);
    // Capacity zero behaves as a single slot: one push fills it, one pop empties it
    write_capacity(5'd0);
    send_item(OP_PUSH_BACK, 32'hAAAA_5555, '0);
    send_item(OP_PUSH_FRONT, 32'h0000_0001, '0);
    send_item(OP_PUSH_BACK, 32'h5555_AAAA, '0);
    send_item(OP_READ, '0, 4'd0);
    send_item(OP_READ, '0, 4'd1);
    send_item(OP_POP_BACK, '0, '0);
    send_item(OP_POP_FRONT, '0, '0);

    // Random segments, each at its own capacity; each idling pattern spans three segments
    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      write_capacity(seg_caps[seg]);
      case (seg / 3)
        0: begin
          send_gap_pct = 32;
          recv_stall_pct = 86;
        end
        1: begin
          send_gap_pct = 86;
          recv_stall_pct = 32;
        end
        default: begin
          send_gap_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      done = 0;
      while (done < SEG_ITEMS) begin
        burst = $urandom_range(8, 40);
        lean = $urandom_range(0, 2);
        for (int k = 0; k < burst && done < SEG_ITEMS; k++) begin
          random_item(lean);
          done++;
        end
      end
    end

    // Let the last results drain, then allow for stray ones
    wait_drained();
    recv_stall_pct = 0;
    repeat (20) @(posedge clk);

    $display("Ran %0d items over %0d capacity settings; %0d results checked.",
             items_sent, cap_writes, deque.checked);
    $display("Status mix: ok %0d, full %0d, empty %0d, out of range %0d.",
             deque.status_seen[ST_OK], deque.status_seen[ST_FULL],
             deque.status_seen[ST_EMPTY], deque.status_seen[ST_RANGE]);
    if (deque.mismatches == 0 && deque.pending() == 0) begin
      $display("tb_ring_buffer_deque: PASS");
    end else begin
      $display("tb_ring_buffer_deque: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/rbd_pkg.sv
design/rbd_step_logic.sv
design/ring_buffer_deque.sv
sim/tb_ring_buffer_deque.sv
